/* src/nsbl_pkg.sv */
// ----------------------------------------------------------------------------
// nsbl_pkg: shared types and tables for the nearest site and box locator
// Landmark site table, function, status and place codes, sequencer states.
// ----------------------------------------------------------------------------
package nsbl_pkg;

  localparam int MAX_BOXES_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int SITE_COUNT   = 29;
  localparam int SITE_IDX_W   = 5;
  localparam int SITE_M_W     = 14;  // site coordinate in metres, signed
  localparam int SITE_COORD_W = 15;  // site coordinate in half metres, signed
  localparam int RSQ_W        = 19;  // squared radius in half metres
  localparam int REGION_W     = 4;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int KIND_W       = 2;
  localparam int PLACE_W      = 5;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

  localparam logic [KIND_W-1:0] PLACE_NONE = 2'd0;
  localparam logic [KIND_W-1:0] PLACE_SITE = 2'd1;
  localparam logic [KIND_W-1:0] PLACE_BOX  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SITE_DX,
    S_SITE_DZ,
    S_SITE_CMP,
    S_RADIUS,
    S_BOX_RD,
    S_BOX_CHK,
    S_ADD_MUL,
    S_ADD_WR,
    S_OUT
  } state_t;

  localparam logic signed [SITE_M_W-1:0] SITE_X [SITE_COUNT] = '{
    -14'sd2176, -14'sd1793, -14'sd2425, -14'sd1955, -14'sd3275,
    -14'sd2623, -14'sd3126,
    -14'sd4007, -14'sd4462, -14'sd3662, -14'sd3687,
    -14'sd887,   14'sd112,  -14'sd274,
    -14'sd4279, -14'sd4702, -14'sd3288,
    -14'sd2715, -14'sd1700, -14'sd1545,
    -14'sd698,  -14'sd789,  -14'sd455,   14'sd377,
     14'sd711,  -14'sd83,    14'sd325,
    -14'sd428,  -14'sd739
  };

  localparam logic signed [SITE_M_W-1:0] SITE_Z [SITE_COUNT] = '{
    14'sd2614, 14'sd2837, 14'sd2139, 14'sd3256, 14'sd2720,
    14'sd3391, 14'sd3724,
    14'sd2935, 14'sd3310, 14'sd2125, 14'sd3493,
    14'sd2421, 14'sd2319, 14'sd2113,
    14'sd4448, 14'sd3959, 14'sd4547,
    14'sd4252, 14'sd4242, 14'sd3913,
    14'sd3323, 14'sd3730, 14'sd3927, 14'sd3460,
    14'sd1253, 14'sd1374, 14'sd1940,
    14'sd1616, 14'sd785
  };

  // (2 * radius)^2
  localparam logic [RSQ_W-1:0] SITE_RSQ [SITE_COUNT] = '{
    19'd270400, 19'd90000,  19'd90000,  19'd250000, 19'd129600,
    19'd193600, 19'd193600,
    19'd230400, 19'd193600, 19'd160000, 19'd160000,
    19'd360000, 19'd250000, 19'd102400,
    19'd313600, 19'd129600, 19'd160000,
    19'd270400, 19'd160000, 19'd129600,
    19'd230400, 19'd160000, 19'd129600, 19'd193600,
    19'd490000, 19'd193600, 19'd90000,
    19'd160000, 19'd160000
  };

  localparam logic [REGION_W-1:0] SITE_REGION [SITE_COUNT] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd1, 4'd1,
    4'd2, 4'd2, 4'd2, 4'd2,
    4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6,
    4'd8, 4'd8, 4'd8,
    4'd7, 4'd7
  };

  function automatic logic signed [SITE_COORD_W-1:0] site_x2(
    input logic [SITE_IDX_W-1:0] idx
  );
    site_x2 = {SITE_X[idx], 1'b0};
  endfunction

  function automatic logic signed [SITE_COORD_W-1:0] site_z2(
    input logic [SITE_IDX_W-1:0] idx
  );
    site_z2 = {SITE_Z[idx], 1'b0};
  endfunction

  function automatic logic [RSQ_W-1:0] site_rsq(input logic [SITE_IDX_W-1:0] idx);
    site_rsq = SITE_RSQ[idx];
  endfunction

  function automatic logic [REGION_W-1:0] site_region(
    input logic [SITE_IDX_W-1:0] idx
  );
    site_region = SITE_REGION[idx];
  endfunction

endpackage

/* src/nsbl_if.sv */
// ----------------------------------------------------------------------------
// nsbl_if: item channels of the nearest site and box locator
// Command channel (clear, add box, query) and result channel.
// ----------------------------------------------------------------------------
interface nsbl_cmd_if #(
  parameter int COORD_BITS = nsbl_pkg::COORD_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic [nsbl_pkg::FUNC_W-1:0]         func;
  logic signed [COORD_BITS-1:0]        point_x;
  logic signed [COORD_BITS-1:0]        point_z;
  logic signed [COORD_BITS-1:0]        corner_x;
  logic signed [COORD_BITS-1:0]        corner_z;

  modport source (output valid, func, point_x, point_z, corner_x, corner_z,
                  input ready);
  modport sink (input valid, func, point_x, point_z, corner_x, corner_z,
                output ready);
endinterface

interface nsbl_res_if ();
  logic                                valid;
  logic                                ready;
  logic [nsbl_pkg::STATUS_W-1:0]       status;
  logic [nsbl_pkg::REGION_W-1:0]       region_id;
  logic [nsbl_pkg::SITE_IDX_W-1:0]     nearest_site;
  logic [nsbl_pkg::KIND_W-1:0]         place_kind;
  logic [nsbl_pkg::PLACE_W-1:0]        place_index;

  modport source (output valid, status, region_id, nearest_site, place_kind,
                  place_index, input ready);
  modport sink (input valid, status, region_id, nearest_site, place_kind,
                place_index, output ready);
endinterface

/* src/nsbl_box_ram.sv */
// ----------------------------------------------------------------------------
// nsbl_box_ram: box table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nsbl_box_ram #(
  parameter int DEPTH = nsbl_pkg::MAX_BOXES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW    = 6 * nsbl_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/nearest_site_and_box_locator.sv */
// ----------------------------------------------------------------------------
// nearest_site_and_box_locator: nearest landmark site and box point location
// Query against 29 fixed sites and a loadable box table, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   cmd carries one item per handshake: clear the box table, add a box from
//   two corners, or query a point. res returns exactly one item per command
//   (an unused function code returns nothing).
//   A clear, or an add with a full table, goes straight to the result; an add
//   multiplies out the box area, then writes the entry; a query scans every
//   site, checks the radius of the nearest, then reads and checks each loaded
//   box. Each site runs dx squared and dz squared through the single shared
//   multiplier, then the compare; each box takes a table read and a
//   containment check. cmd.ready is high only while the sequencer is idle, so
//   with no stall a new command is taken in the cycle after the result is
//   loaded. A finished item sits in the res register; the next command is
//   taken while it waits. If res is still full when the next item finishes,
//   the sequencer holds until res.ready frees the register.
//   Reset empties the box table count and the res register; the box storage
//   itself needs no clearing pass.
// ----------------------------------------------------------------------------
module nearest_site_and_box_locator #(
  parameter int MAX_BOXES  = nsbl_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = nsbl_pkg::COORD_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  nsbl_cmd_if.sink     cmd,
  nsbl_res_if.source   res
);

  localparam int CB      = COORD_BITS;
  localparam int DX_W    = ((CB > nsbl_pkg::SITE_COORD_W) ? CB : nsbl_pkg::SITE_COORD_W) + 1;
  localparam int SQ_W    = 2 * DX_W;
  localparam int AREA_W  = 2 * CB;
  localparam int IW      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW      = $clog2(MAX_BOXES + 1);
  localparam int ENTRY_W = 4 * CB + AREA_W;
  localparam int SIW     = nsbl_pkg::SITE_IDX_W;

  nsbl_pkg::state_t state, state_next;

  // control
  logic          cmd_ready;
  logic          accept;
  logic          clear_cnt;
  logic          mem_we;
  logic          load_out;
  logic [CW-1:0] box_count;
  logic          out_valid;

  // working registers
  logic signed [CB-1:0]           qx, qz;
  logic signed [CB-1:0]           lo_x, hi_x, lo_z, hi_z;
  logic [SIW-1:0]                 site_idx;
  logic [SIW-1:0]                 best;
  logic [SQ_W-1:0]                best_d2;
  logic [SQ_W-1:0]                prod;
  logic [SQ_W-1:0]                acc;
  logic [CW-1:0]                  box_idx;
  logic                           have_box;
  logic [AREA_W-1:0]              best_area;
  logic [nsbl_pkg::KIND_W-1:0]    kind;
  logic [nsbl_pkg::PLACE_W-1:0]   place_idx;
  logic [nsbl_pkg::STATUS_W-1:0]  res_status;

  // result register
  logic [nsbl_pkg::STATUS_W-1:0]  out_status;
  logic [nsbl_pkg::REGION_W-1:0]  out_region;
  logic [SIW-1:0]                 out_site;
  logic [nsbl_pkg::KIND_W-1:0]    out_kind;
  logic [nsbl_pkg::PLACE_W-1:0]   out_place;

  // datapath
  logic signed [DX_W-1:0] dx, dz, ax, az;
  logic signed [DX_W-1:0] mul_a, mul_b;
  logic signed [SQ_W-1:0] mul_p;
  logic [SQ_W-1:0]        d2;
  logic                   table_full;
  logic                   site_last;
  logic                   box_last;
  logic [ENTRY_W-1:0]     wr_entry;
  logic [ENTRY_W-1:0]     rd_entry;
  logic signed [CB-1:0]   r_lo_x, r_hi_x, r_lo_z, r_hi_z;
  logic [AREA_W-1:0]      r_area;
  logic                   in_box;

  assign dx = DX_W'(qx) - DX_W'(nsbl_pkg::site_x2(site_idx));
  assign dz = DX_W'(qz) - DX_W'(nsbl_pkg::site_z2(site_idx));
  assign ax = DX_W'(hi_x) - DX_W'(lo_x);
  assign az = DX_W'(hi_z) - DX_W'(lo_z);

  always_comb begin
    unique case (state)
      nsbl_pkg::S_SITE_DX: begin
        mul_a = dx;
        mul_b = dx;
      end
      nsbl_pkg::S_SITE_DZ: begin
        mul_a = dz;
        mul_b = dz;
      end
      default: begin
        mul_a = ax;
        mul_b = az;
      end
    endcase
  end

  // the shared multiplier
  assign mul_p = mul_a * mul_b;

  assign d2         = acc + prod;
  assign table_full = (box_count == CW'(MAX_BOXES));
  assign site_last  = (site_idx == SIW'(nsbl_pkg::SITE_COUNT - 1));
  assign box_last   = (CW'(box_idx + 1'b1) == box_count);

  assign wr_entry = {lo_x, hi_x, lo_z, hi_z, prod[AREA_W-1:0]};
  assign r_lo_x   = rd_entry[ENTRY_W-1 -: CB];
  assign r_hi_x   = rd_entry[ENTRY_W-CB-1 -: CB];
  assign r_lo_z   = rd_entry[ENTRY_W-2*CB-1 -: CB];
  assign r_hi_z   = rd_entry[ENTRY_W-3*CB-1 -: CB];
  assign r_area   = rd_entry[AREA_W-1:0];
  assign in_box   = (qx >= r_lo_x) && (qx <= r_hi_x) && (qz >= r_lo_z) && (qz <= r_hi_z);

  nsbl_box_ram #(
    .DEPTH (MAX_BOXES),
    .AW    (IW),
    .DW    (ENTRY_W)
  ) u_box_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (box_count[IW-1:0]),
    .wdata (wr_entry),
    .raddr (box_idx[IW-1:0]),
    .rdata (rd_entry)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nsbl_pkg::S_IDLE: begin
        if (cmd.valid) begin
          priority case (cmd.func)
            nsbl_pkg::FUNC_CLEAR: state_next = nsbl_pkg::S_OUT;
            nsbl_pkg::FUNC_ADD:   state_next = table_full ? nsbl_pkg::S_OUT
                                                          : nsbl_pkg::S_ADD_MUL;
            nsbl_pkg::FUNC_QUERY: state_next = nsbl_pkg::S_SITE_DX;
            default:              state_next = nsbl_pkg::S_IDLE;
          endcase
        end
      end
      nsbl_pkg::S_SITE_DX:  state_next = nsbl_pkg::S_SITE_DZ;
      nsbl_pkg::S_SITE_DZ:  state_next = nsbl_pkg::S_SITE_CMP;
      nsbl_pkg::S_SITE_CMP: state_next = site_last ? nsbl_pkg::S_RADIUS : nsbl_pkg::S_SITE_DX;
      nsbl_pkg::S_RADIUS:   state_next = (box_count == '0) ? nsbl_pkg::S_OUT
                                                           : nsbl_pkg::S_BOX_RD;
      nsbl_pkg::S_BOX_RD:   state_next = nsbl_pkg::S_BOX_CHK;
      nsbl_pkg::S_BOX_CHK:  state_next = box_last ? nsbl_pkg::S_OUT : nsbl_pkg::S_BOX_RD;
      nsbl_pkg::S_ADD_MUL:  state_next = nsbl_pkg::S_ADD_WR;
      nsbl_pkg::S_ADD_WR:   state_next = nsbl_pkg::S_OUT;
      nsbl_pkg::S_OUT: begin
        if (!out_valid || res.ready) begin
          state_next = nsbl_pkg::S_IDLE;
        end
      end
      default: state_next = nsbl_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = (state == nsbl_pkg::S_IDLE) && !rst;
    accept    = cmd.valid && cmd_ready;
    clear_cnt = accept && (cmd.func == nsbl_pkg::FUNC_CLEAR);
    mem_we    = (state == nsbl_pkg::S_ADD_WR);
    load_out  = (state == nsbl_pkg::S_OUT) && (!out_valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nsbl_pkg::S_IDLE;
      box_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_cnt) begin
        box_count <= '0;
      end else if (mem_we) begin
        box_count <= CW'(box_count + 1'b1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      nsbl_pkg::S_IDLE: begin
        if (accept) begin
          qx        <= cmd.point_x;
          qz        <= cmd.point_z;
          lo_x      <= (cmd.point_x < cmd.corner_x) ? cmd.point_x : cmd.corner_x;
          hi_x      <= (cmd.point_x < cmd.corner_x) ? cmd.corner_x : cmd.point_x;
          lo_z      <= (cmd.point_z < cmd.corner_z) ? cmd.point_z : cmd.corner_z;
          hi_z      <= (cmd.point_z < cmd.corner_z) ? cmd.corner_z : cmd.point_z;
          site_idx  <= '0;
          best      <= '0;
          kind      <= nsbl_pkg::PLACE_NONE;
          place_idx <= '0;
          have_box  <= 1'b0;
          priority case (cmd.func)
            nsbl_pkg::FUNC_CLEAR: res_status <= nsbl_pkg::STATUS_CLEARED;
            nsbl_pkg::FUNC_ADD:   res_status <= table_full ? nsbl_pkg::STATUS_FULL
                                                           : nsbl_pkg::STATUS_STORED;
            default:              res_status <= nsbl_pkg::STATUS_DONE;
          endcase
        end
      end
      nsbl_pkg::S_SITE_DX: begin
        prod <= unsigned'(mul_p);
      end
      nsbl_pkg::S_SITE_DZ: begin
        acc  <= prod;
        prod <= unsigned'(mul_p);
      end
      nsbl_pkg::S_SITE_CMP: begin
        if (site_idx == '0 || d2 < best_d2) begin
          best    <= site_idx;
          best_d2 <= d2;
        end
        site_idx <= SIW'(site_idx + 1'b1);
      end
      nsbl_pkg::S_RADIUS: begin
        if (best_d2 <= SQ_W'(nsbl_pkg::site_rsq(best))) begin
          kind      <= nsbl_pkg::PLACE_SITE;
          place_idx <= nsbl_pkg::PLACE_W'(best);
        end
        box_idx <= '0;
      end
      nsbl_pkg::S_BOX_RD: begin
      end
      nsbl_pkg::S_BOX_CHK: begin
        if (in_box && (!have_box || r_area < best_area)) begin
          have_box  <= 1'b1;
          best_area <= r_area;
          kind      <= nsbl_pkg::PLACE_BOX;
          place_idx <= nsbl_pkg::PLACE_W'(box_idx);
        end
        box_idx <= CW'(box_idx + 1'b1);
      end
      nsbl_pkg::S_ADD_MUL: begin
        prod <= unsigned'(mul_p);
      end
      nsbl_pkg::S_ADD_WR: begin
      end
      nsbl_pkg::S_OUT: begin
        if (load_out) begin
          out_status <= res_status;
          out_region <= (res_status == nsbl_pkg::STATUS_DONE) ? nsbl_pkg::site_region(best)
                                                              : '0;
          out_site   <= best;
          out_kind   <= kind;
          out_place  <= place_idx;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd.ready        = cmd_ready;
  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.region_id    = out_region;
  assign res.nearest_site = out_site;
  assign res.place_kind   = out_kind;
  assign res.place_index  = out_place;

`ifndef SYNTHESIS
  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    state == nsbl_pkg::S_ADD_WR |=> box_count == $past(box_count) + 1'b1)
    else $error("box count did not advance after a store");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == nsbl_pkg::S_BOX_RD |-> box_idx < box_count)
    else $error("box scan beyond loaded entries");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.func == nsbl_pkg::FUNC_QUERY |=> state == nsbl_pkg::S_SITE_DX)
    else $error("query did not start the site scan");

  a_no_place_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == nsbl_pkg::PLACE_NONE |-> out_place == '0)
    else $error("place index set with no place");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.func == nsbl_pkg::FUNC_ADD && table_full |=> state == nsbl_pkg::S_OUT)
    else $error("add into a full table was not dropped");
`endif

endmodule
